// ===== src/akf_pkg.sv =====
// Package for the altitude/velocity Kalman filter: formats, codes, command
// and status structs, and the microprogram of the sequencer.
// No dependencies.
`timescale 1ns / 1ps
package akf_pkg;

  localparam int COV_FRAC_BITS = 32;
  localparam int GAIN_FRAC     = 32;
  localparam int ST_W          = 32;
  localparam int COV_W         = 48;
  localparam int VAR_W         = 47;
  localparam int K_W           = 43;
  localparam int TERM_W        = 62;
  localparam int DVD_W         = COV_W + GAIN_FRAC;
  localparam int SHA_Q4        = 82 - COV_FRAC_BITS;
  localparam int SHA_Q3        = 65 - COV_FRAC_BITS;
  localparam int SHA_Q2        = 48 - COV_FRAC_BITS;
  localparam int PC_W          = 5;
  localparam logic [PC_W-1:0] PC_PREDICT = PC_W'(0);
  localparam logic [PC_W-1:0] PC_UPDATE  = PC_W'(12);

  localparam logic [1:0] REG_PROCESS_NOISE  = 2'd0;
  localparam logic [1:0] REG_MEASURE_NOISE  = 2'd1;
  localparam logic [1:0] REG_START_ALTITUDE = 2'd2;
  localparam logic [1:0] REG_START_VELOCITY = 2'd3;

  typedef enum logic [1:0] {OP_PREDICT, OP_UPDATE, OP_RESTART, OP_NONE} op_t;

  typedef enum logic [3:0] {
    SRC_ALT, SRC_VEL, SRC_ACC, SRC_D, SRC_D2, SRC_D3, SRC_D4, SRC_Q,
    SRC_S, SRC_Y, SRC_CAA, SRC_CAV, SRC_CVA, SRC_CVV, SRC_K0, SRC_K1
  } src_t;

  typedef enum logic [2:0] {SH_RAW, SH_16, SH_33, SH_GAIN, SH_Q4, SH_Q3, SH_Q2} shc_t;

  typedef enum logic [3:0] {
    DST_D2, DST_D3, DST_D4, DST_NA, DST_NV, DST_T3, DST_P00, DST_P01P10,
    DST_P01, DST_P10, DST_P11, DST_K0, DST_K1
  } dst_t;

  typedef enum logic [1:0] {UK_MUL, UK_DIV, UK_END} ukind_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_ISSUE, ST_WAIT, ST_COMMIT, ST_RESULT
  } state_t;

  typedef struct packed {
    ukind_t kind;
    src_t   a;
    src_t   b;
    shc_t   sh;
    dst_t   dst;
    logic   sub;
  } uop_t;

  typedef struct packed {
    logic take;
    logic init_pred;
    logic init_upd;
    logic restart;
    logic start;
    logic commit;
    logic load_out;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic den_zero;
  } sts_t;

  typedef struct packed {
    logic        [31:0] process_noise;
    logic        [31:0] measure_noise;
    logic signed [31:0] start_altitude;
    logic signed [31:0] start_velocity;
  } cfg_t;

  function automatic uop_t mk(ukind_t k, src_t a, src_t b, shc_t sh, dst_t d, logic sub);
    uop_t u;
    u.kind = k;
    u.a    = a;
    u.b    = b;
    u.sh   = sh;
    u.dst  = d;
    u.sub  = sub;
    return u;
  endfunction

  function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:    u = mk(UK_MUL, SRC_D,   SRC_D,   SH_RAW,  DST_D2,     1'b0);
      5'd1:    u = mk(UK_MUL, SRC_D2,  SRC_D,   SH_RAW,  DST_D3,     1'b0);
      5'd2:    u = mk(UK_MUL, SRC_D3,  SRC_D,   SH_RAW,  DST_D4,     1'b0);
      5'd3:    u = mk(UK_MUL, SRC_VEL, SRC_D,   SH_16,   DST_NA,     1'b0);
      5'd4:    u = mk(UK_MUL, SRC_ACC, SRC_D2,  SH_33,   DST_NA,     1'b0);
      5'd5:    u = mk(UK_MUL, SRC_ACC, SRC_D,   SH_16,   DST_NV,     1'b0);
      5'd6:    u = mk(UK_MUL, SRC_CVV, SRC_D,   SH_16,   DST_T3,     1'b0);
      5'd7:    u = mk(UK_MUL, SRC_S,   SRC_D,   SH_16,   DST_P00,    1'b0);
      5'd8:    u = mk(UK_MUL, SRC_Q,   SRC_D4,  SH_Q4,   DST_P00,    1'b0);
      5'd9:    u = mk(UK_MUL, SRC_Q,   SRC_D3,  SH_Q3,   DST_P01P10, 1'b0);
      5'd10:   u = mk(UK_MUL, SRC_Q,   SRC_D2,  SH_Q2,   DST_P11,    1'b0);
      5'd12:   u = mk(UK_DIV, SRC_CAA, SRC_ALT, SH_RAW,  DST_K0,     1'b0);
      5'd13:   u = mk(UK_DIV, SRC_CVA, SRC_ALT, SH_RAW,  DST_K1,     1'b0);
      5'd14:   u = mk(UK_MUL, SRC_K0,  SRC_Y,   SH_GAIN, DST_NA,     1'b0);
      5'd15:   u = mk(UK_MUL, SRC_K1,  SRC_Y,   SH_GAIN, DST_NV,     1'b0);
      5'd16:   u = mk(UK_MUL, SRC_K0,  SRC_CAA, SH_GAIN, DST_P00,    1'b1);
      5'd17:   u = mk(UK_MUL, SRC_K0,  SRC_CAV, SH_GAIN, DST_P01,    1'b1);
      5'd18:   u = mk(UK_MUL, SRC_K1,  SRC_CAA, SH_GAIN, DST_P10,    1'b1);
      5'd19:   u = mk(UK_MUL, SRC_K1,  SRC_CAV, SH_GAIN, DST_P11,    1'b1);
      default: u = mk(UK_END, SRC_ALT, SRC_ALT, SH_RAW,  DST_NA,     1'b0);
    endcase
    return u;
  endfunction

endpackage

// ===== src/akf_ifs.sv =====
// Valid/ready channel interfaces for filter requests and results.
// Depends on nothing.
`timescale 1ns / 1ps
interface akf_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  op;
  logic signed [31:0] accel;
  logic        [15:0] step_time;
  logic signed [31:0] baro_altitude;
  modport source (output valid, op, accel, step_time, baro_altitude, input ready);
  modport sink (input valid, op, accel, step_time, baro_altitude, output ready);
endinterface

interface akf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] altitude;
  logic signed [31:0] velocity;
  logic        [46:0] altitude_variance;
  logic               saturated;
  modport source (output valid, altitude, velocity, altitude_variance, saturated,
                  input ready);
  modport sink (input valid, altitude, velocity, altitude_variance, saturated,
                output ready);
endinterface

// ===== src/akf_mul.sv =====
// Multi-cycle 64x64 magnitude multiplier on one 32x32 multiplier, with
// rounded shift and cap. Depends on akf_pkg.
`timescale 1ns / 1ps
module akf_mul import akf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [63:0]              a_mag,
  input  logic [63:0]              b_mag,
  input  logic                     neg,
  input  shc_t                     sh,
  output logic                     done,
  output logic [63:0]              raw,
  output logic signed [TERM_W-1:0] term
);

  logic [63:0]  a, b, pp;
  logic         neg_q, busy, over;
  shc_t         sh_q;
  logic [2:0]   cnt;
  logic [1:0]   pidx;
  logic [31:0]  a_part, b_part;
  logic [127:0] acc, rnd, pp_ext, half, shv;
  logic [60:0]  mag;

  always_comb begin
    a_part = cnt[1] ? a[63:32] : a[31:0];
    b_part = cnt[0] ? b[63:32] : b[31:0];
    pidx   = 2'(cnt - 3'd1);
    case (pidx)
      2'd0:    pp_ext = {64'b0, pp};
      2'd3:    pp_ext = {pp, 64'b0};
      default: pp_ext = {32'b0, pp, 32'b0};
    endcase
    case (sh_q)
      SH_16:   begin half = 128'(1) << 15;           shv = rnd >> 16;        end
      SH_33:   begin half = 128'(1) << 32;           shv = rnd >> 33;        end
      SH_GAIN: begin half = 128'(1) << (GAIN_FRAC-1); shv = rnd >> GAIN_FRAC; end
      SH_Q4:   begin half = 128'(1) << (SHA_Q4-1);   shv = rnd >> SHA_Q4;    end
      SH_Q3:   begin half = 128'(1) << (SHA_Q3-1);   shv = rnd >> SHA_Q3;    end
      SH_Q2:   begin half = 128'(1) << (SHA_Q2-1);   shv = rnd >> SHA_Q2;    end
      default: begin half = '0;                      shv = rnd;              end
    endcase
    over = (shv[127:61] != '0) || (shv[60] && (shv[59:0] != '0));
    mag  = over ? {1'b1, 60'b0} : shv[60:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd6) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a     <= a_mag;
      b     <= b_mag;
      neg_q <= neg;
      sh_q  <= sh;
      acc   <= '0;
    end else if (busy) begin
      if (cnt < 3'd4) pp <= a_part * b_part;
      if (cnt >= 3'd1 && cnt <= 3'd4) acc <= acc + pp_ext;
      if (cnt == 3'd5) rnd <= acc + half;
      if (cnt == 3'd6) begin
        raw  <= shv[63:0];
        term <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
    end
  end

endmodule

// ===== src/akf_div.sv =====
// Restoring divider for the Kalman gain, one quotient bit a cycle, with
// round to nearest and cap. Depends on akf_pkg.
`timescale 1ns / 1ps
module akf_div import akf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [COV_W-1:0] num,
  input  logic [63:0]            den,
  output logic                   done,
  output logic signed [K_W-1:0]  q_out
);

  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam logic [41:0] GCAP = 42'(1) << 40;

  logic [DVD_W-1:0] dvd;
  logic [63:0]      d, r, rr;
  logic [41:0]      q, qn, qf;
  logic             neg_q, capped, busy, ge, fin;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    rr = {r[62:0], dvd[DVD_W-1]};
    ge = rr >= d;
    qn = {q[40:0], ge};
    qf = q + 42'(!capped && (r >= d - r));
    if (capped || qf > GCAP) qf = GCAP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_q  <= num[COV_W-1];
      dvd    <= {(num[COV_W-1] ? COV_W'(-num) : COV_W'(num)), GAIN_FRAC'(0)};
      d      <= den;
      r      <= '0;
      q      <= '0;
      capped <= 1'b0;
    end else if (busy) begin
      r   <= ge ? rr - d : rr;
      dvd <= dvd << 1;
      if (!capped) begin
        q <= qn;
        if (qn > GCAP) capped <= 1'b1;
      end
    end else if (fin) begin
      q_out <= neg_q ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
    end
  end

endmodule

// ===== src/akf_dp.sv =====
// Datapath: filter state, working registers, operand selection, shared
// multiplier and gain divider, clipping and result register. Depends on akf_pkg.
`timescale 1ns / 1ps
module akf_dp import akf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  cfg_t               cfg,
  input  logic signed [31:0] accel,
  input  logic [15:0]        step_time,
  input  logic signed [31:0] baro_altitude,
  output sts_t               sts,
  output logic signed [31:0] altitude,
  output logic signed [31:0] velocity,
  output logic [VAR_W-1:0]   altitude_variance,
  output logic               saturated
);

  localparam logic signed [63:0] ST_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] ST_MIN  = -64'sd2147483648;
  localparam logic signed [63:0] COV_MAX = (64'sd1 <<< VAR_W) - 64'sd1;
  localparam logic signed [63:0] COV_MIN = -(64'sd1 <<< VAR_W);
  localparam logic signed [COV_W-1:0] COV_ONE = COV_W'(1) << COV_FRAC_BITS;

  logic signed [ST_W-1:0]  alt, vel, acc_in, baro;
  logic signed [COV_W-1:0] caa, cav, cva, cvv;
  logic [15:0]             d_in;
  logic [31:0]             d2;
  logic [47:0]             d3;
  logic [63:0]             d4, den;
  logic signed [32:0]      y;
  logic signed [63:0]      na, nv, s, p00, p01, p10, p11, t64, tadd;
  logic signed [K_W-1:0]   k0, k1, kq;
  logic                    sat;

  logic signed [64:0]       vals [16];
  logic signed [64:0]       a_v, b_v;
  logic [63:0]              a_mag, b_mag, raw;
  logic                     mul_done, div_done;
  logic signed [TERM_W-1:0] term;
  logic [32:0]              c_na, c_nv;
  logic [48:0]              c_00, c_01, c_10, c_11;

  function automatic logic [32:0] clip_st(logic signed [63:0] v);
    if (v > ST_MAX) return {1'b1, 32'h7FFFFFFF};
    if (v < ST_MIN) return {1'b1, 32'h80000000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [48:0] clip_cov(logic signed [63:0] v, logic diag);
    logic signed [63:0] lo;
    lo = diag ? 64'sd0 : COV_MIN;
    if (v > COV_MAX) return {1'b1, COV_MAX[47:0]};
    if (v < lo) return {1'b1, lo[47:0]};
    return {1'b0, v[47:0]};
  endfunction

  always_comb begin
    vals[SRC_ALT] = 65'(alt);
    vals[SRC_VEL] = 65'(vel);
    vals[SRC_ACC] = 65'(acc_in);
    vals[SRC_D]   = {49'b0, d_in};
    vals[SRC_D2]  = {33'b0, d2};
    vals[SRC_D3]  = {17'b0, d3};
    vals[SRC_D4]  = {1'b0, d4};
    vals[SRC_Q]   = {33'b0, cfg.process_noise};
    vals[SRC_S]   = 65'(s);
    vals[SRC_Y]   = 65'(y);
    vals[SRC_CAA] = 65'(caa);
    vals[SRC_CAV] = 65'(cav);
    vals[SRC_CVA] = 65'(cva);
    vals[SRC_CVV] = 65'(cvv);
    vals[SRC_K0]  = 65'(k0);
    vals[SRC_K1]  = 65'(k1);
    a_v   = vals[cmd.uop.a];
    b_v   = vals[cmd.uop.b];
    a_mag = a_v[64] ? 64'(-a_v) : a_v[63:0];
    b_mag = b_v[64] ? 64'(-b_v) : b_v[63:0];
    t64   = 64'(term);
    tadd  = cmd.uop.sub ? -t64 : t64;
    c_na  = clip_st(na);
    c_nv  = clip_st(nv);
    c_00  = clip_cov(p00, 1'b1);
    c_01  = clip_cov(p01, 1'b0);
    c_10  = clip_cov(p10, 1'b0);
    c_11  = clip_cov(p11, 1'b1);
  end

  akf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start && cmd.uop.kind == UK_MUL),
    .a_mag (a_mag),
    .b_mag (b_mag),
    .neg   (a_v[64] ^ b_v[64]),
    .sh    (cmd.uop.sh),
    .done  (mul_done),
    .raw   (raw),
    .term  (term)
  );

  akf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start && cmd.uop.kind == UK_DIV),
    .num   (a_v[COV_W-1:0]),
    .den   (den),
    .done  (div_done),
    .q_out (kq)
  );

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.den_zero = (den == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      alt <= '0;
      vel <= '0;
      caa <= COV_ONE;
      cav <= '0;
      cva <= '0;
      cvv <= COV_ONE;
      sat <= 1'b0;
    end else if (cmd.restart) begin
      alt <= cfg.start_altitude;
      vel <= cfg.start_velocity;
      caa <= COV_ONE;
      cav <= '0;
      cva <= '0;
      cvv <= COV_ONE;
    end else if (cmd.take) begin
      sat <= 1'b0;
    end else if (cmd.commit) begin
      alt <= $signed(c_na[31:0]);
      vel <= $signed(c_nv[31:0]);
      caa <= $signed(c_00[47:0]);
      cav <= $signed(c_01[47:0]);
      cva <= $signed(c_10[47:0]);
      cvv <= $signed(c_11[47:0]);
      sat <= c_na[32] | c_nv[32] | c_00[48] | c_01[48] | c_10[48] | c_11[48];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      acc_in <= accel;
      d_in   <= step_time;
      baro   <= baro_altitude;
    end
    if (cmd.init_pred || cmd.init_upd) begin
      na  <= 64'(alt);
      nv  <= 64'(vel);
      p00 <= 64'(caa);
      p01 <= 64'(cav);
      p10 <= 64'(cva);
      p11 <= 64'(cvv);
    end
    if (cmd.init_pred) s <= 64'(cva) + 64'(cav);
    if (cmd.init_upd) begin
      y   <= 33'(baro) - 33'(alt);
      den <= 64'(caa) + (64'(cfg.measure_noise) << (COV_FRAC_BITS - 16));
    end
    if (mul_done) begin
      case (cmd.uop.dst)
        DST_D2:     d2  <= raw[31:0];
        DST_D3:     d3  <= raw[47:0];
        DST_D4:     d4  <= raw;
        DST_NA:     na  <= na + tadd;
        DST_NV:     nv  <= nv + tadd;
        DST_T3:     begin
          s   <= s + tadd;
          p01 <= p01 + tadd;
          p10 <= p10 + tadd;
        end
        DST_P00:    p00 <= p00 + tadd;
        DST_P01P10: begin
          p01 <= p01 + tadd;
          p10 <= p10 + tadd;
        end
        DST_P01:    p01 <= p01 + tadd;
        DST_P10:    p10 <= p10 + tadd;
        DST_P11:    p11 <= p11 + tadd;
        default:    ;
      endcase
    end
    if (div_done) begin
      if (cmd.uop.dst == DST_K0) k0 <= kq;
      else k1 <= kq;
    end
    if (cmd.load_out) begin
      altitude          <= alt;
      velocity          <= vel;
      altitude_variance <= caa[VAR_W-1:0];
      saturated         <= sat;
    end
  end

endmodule

// ===== src/akf_ctrl.sv =====
// Sequencer: request handshake, microprogram counter and result handshake.
// Depends on akf_pkg.
`timescale 1ns / 1ps
module akf_ctrl import akf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  op_t  in_op,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t          state, state_next;
  op_t             op_q;
  logic [PC_W-1:0] pc, pc_next;
  uop_t            uop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      op_q      <= OP_NONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      if (cmd.take) op_q <= in_op;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    uop        = uop_rom(pc);
    cmd        = '0;
    cmd.uop    = uop;
    state_next = state;
    pc_next    = pc;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        unique case (op_q)
          OP_PREDICT: begin
            cmd.init_pred = 1'b1;
            pc_next       = PC_PREDICT;
            state_next    = ST_ISSUE;
          end
          OP_UPDATE: begin
            cmd.init_upd = 1'b1;
            pc_next      = PC_UPDATE;
            state_next   = ST_ISSUE;
          end
          OP_RESTART: begin
            cmd.restart = 1'b1;
            state_next  = ST_RESULT;
          end
          default: state_next = ST_RESULT;
        endcase
      end
      ST_ISSUE: begin
        if (uop.kind == UK_END || (op_q == OP_UPDATE && sts.den_zero)) begin
          state_next = ST_COMMIT;
        end else begin
          cmd.start  = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if ((uop.kind == UK_MUL && sts.mul_done) || (uop.kind == UK_DIV && sts.div_done)) begin
          pc_next    = pc + 1'b1;
          state_next = ST_ISSUE;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== src/altitude_velocity_kalman_filter.sv =====
// Two-state altitude/velocity Kalman filter: top level with APB register
// file, sequencer and datapath. Depends on akf_pkg, akf_ifs, akf_ctrl, akf_dp.
//
// Usage:
//   sample carries one request (predict, barometric update, restart, or the
//   unused code, which reports the state unchanged). result returns exactly
//   one item per request, in order. A request is taken only when the block
//   holds none in progress; result sits in an output register, so a new
//   request is taken while the previous result still waits.
//   Work per request: predict runs eleven products on the shared 32x32
//   multiplier; update runs two gain divisions (one quotient bit a cycle
//   over 80 bits) plus six products. If P00 + R is zero an update skips
//   the divisions and products and finishes with the state unchanged.
//   If result is stalled, the finished request waits in the sequencer and
//   no new request is taken until the result register frees.
//   Reset (rst, synchronous) restores register defaults, zero state and
//   identity covariance, and empties both channels. Registers are written
//   through APB at 0x0, 0x4, 0x8, 0xC; user writes only while idle, unchecked.
`timescale 1ns / 1ps
module altitude_velocity_kalman_filter import akf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  akf_in_if.sink      sample,
  akf_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.process_noise  <= 32'd6554;
      cfg.measure_noise  <= 32'd131072;
      cfg.start_altitude <= '0;
      cfg.start_velocity <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_PROCESS_NOISE:  cfg.process_noise  <= pwdata;
        REG_MEASURE_NOISE:  cfg.measure_noise  <= pwdata;
        REG_START_ALTITUDE: cfg.start_altitude <= pwdata;
        REG_START_VELOCITY: cfg.start_velocity <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PROCESS_NOISE:  prdata = cfg.process_noise;
      REG_MEASURE_NOISE:  prdata = cfg.measure_noise;
      REG_START_ALTITUDE: prdata = cfg.start_altitude;
      REG_START_VELOCITY: prdata = cfg.start_velocity;
      default:            prdata = '0;
    endcase
  end

  akf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_op     (op_t'(sample.op)),
    .in_ready  (sample.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  akf_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .cfg               (cfg),
    .accel             (sample.accel),
    .step_time         (sample.step_time),
    .baro_altitude     (sample.baro_altitude),
    .sts               (sts),
    .altitude          (result.altitude),
    .velocity          (result.velocity),
    .altitude_variance (result.altitude_variance),
    .saturated         (result.saturated)
  );

`ifndef SYNTHESIS
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("request taken while another is in progress");
  a_mul_kind: assert property (@(posedge clk) disable iff (rst)
    sts.mul_done |-> cmd.uop.kind == UK_MUL)
    else $error("product returned outside a multiply step");
  a_start_once: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !cmd.start)
    else $error("unit started twice in a row");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> result.valid)
    else $error("result loaded but not offered");
`endif

endmodule

// ===== tb/sv/altitude_velocity_kalman_filter_test.sv =====
// Testbench for the altitude/velocity Kalman filter: directed and random requests,
// each result checked against a bit-true predictor kept in this module or a typed row.
// Depends on akf_pkg, akf_ifs and the filter RTL.
`timescale 1ns / 1ps
module altitude_velocity_kalman_filter_test;
  import akf_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 300;
  localparam longint unsigned TERM_CAP = 64'd1 << 60;
  localparam longint unsigned GAIN_CAP = 64'd1 << 40;
  localparam longint COV_MAX = (64'sd1 <<< 47) - 1;
  localparam longint COV_MIN = -COV_MAX - 1;
  localparam longint ST_MAX = 64'sh7FFFFFFF;
  localparam longint ST_MIN = -64'sh80000000;
  localparam longint COV_ONE = 64'sd1 <<< COV_FRAC_BITS;

  typedef struct {
    logic signed [31:0] altitude;
    logic signed [31:0] velocity;
    logic [46:0]        variance;
    logic               saturated;
  } estimate_t;

  typedef struct {
    op_t                op;
    logic signed [31:0] accel;
    logic [15:0]        step_time;
    logic signed [31:0] baro;
    bit                 typed;
    estimate_t          want;
  } request_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  akf_in_if  sample_if();
  akf_out_if result_if();

  altitude_velocity_kalman_filter u_top (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_if.sink),
    .result  (result_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor copy of registers and filter state
  longint unsigned m_process_noise, m_measure_noise;
  longint m_start_alt, m_start_vel;
  longint m_alt, m_vel, m_caa, m_cav, m_cva, m_cvv;

  estimate_t pending_estimates[$];
  request_t  directed_rows[$];
  int errors;
  int gap_pct, stall_pct;
  int hold_left;
  bit hold_req;
  estimate_t typed_queue[$];
  bit typed_flags[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(unsigned'(-v)) : v;
  endfunction

  function automatic longint scaled_product(longint unsigned am, longint unsigned bm,
                                            bit neg, int sh);
    logic [128:0] p;
    longint unsigned r;
    p = 129'(am) * 129'(bm);
    if (sh > 0) p = (p + (129'(1) << (sh - 1))) >> sh;
    r = (p > 129'(TERM_CAP)) ? TERM_CAP : p[63:0];
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint signed_product(longint a, longint b, int sh);
    return scaled_product(magnitude(a), magnitude(b), (a < 0) != (b < 0), sh);
  endfunction

  function automatic longint kalman_gain(longint num, longint den);
    logic [127:0] nn, qq, rr;
    longint unsigned q;
    nn = 128'(magnitude(num)) << GAIN_FRAC;
    qq = nn / 128'(den);
    rr = nn % 128'(den);
    if (qq > 128'(GAIN_CAP)) q = GAIN_CAP;
    else begin
      q = qq[63:0];
      if (rr[63:0] >= longint'(den) - rr[63:0]) q++;
      if (q > GAIN_CAP) q = GAIN_CAP;
    end
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi, ref bit flag);
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function automatic estimate_t filter_step(request_t r);
    estimate_t e;
    bit sat;
    longint unsigned d, d2, d3, d4;
    longint acc, na, nv, s, p00, p01, p10, p11, y, k0, k1;
    sat = 1'b0;
    case (r.op)
      OP_PREDICT: begin
        acc = longint'(r.accel);
        d   = r.step_time;
        d2  = d * d;
        d3  = d2 * d;
        d4  = d3 * d;
        na  = m_alt + signed_product(m_vel, d, 16) + signed_product(acc, d2, 33);
        nv  = m_vel + signed_product(acc, d, 16);
        s   = m_cva + m_cav + signed_product(m_cvv, d, 16);
        p00 = m_caa + signed_product(s, d, 16)
              + scaled_product(m_process_noise, d4, 1'b0, SHA_Q4);
        p01 = m_cav + signed_product(m_cvv, d, 16)
              + scaled_product(m_process_noise, d3, 1'b0, SHA_Q3);
        p10 = m_cva + signed_product(m_cvv, d, 16)
              + scaled_product(m_process_noise, d3, 1'b0, SHA_Q3);
        p11 = m_cvv + scaled_product(m_process_noise, d2, 1'b0, SHA_Q2);
        m_alt = clamp(na, ST_MIN, ST_MAX, sat);
        m_vel = clamp(nv, ST_MIN, ST_MAX, sat);
        m_caa = clamp(p00, 0, COV_MAX, sat);
        m_cav = clamp(p01, COV_MIN, COV_MAX, sat);
        m_cva = clamp(p10, COV_MIN, COV_MAX, sat);
        m_cvv = clamp(p11, 0, COV_MAX, sat);
      end
      OP_UPDATE: begin
        y = longint'(r.baro) - m_alt;
        s = m_caa + longint'(m_measure_noise << (COV_FRAC_BITS - 16));
        if (s > 0) begin
          k0  = kalman_gain(m_caa, s);
          k1  = kalman_gain(m_cva, s);
          p00 = m_caa;
          p01 = m_cav;
          na  = m_alt + signed_product(k0, y, GAIN_FRAC);
          nv  = m_vel + signed_product(k1, y, GAIN_FRAC);
          m_alt = clamp(na, ST_MIN, ST_MAX, sat);
          m_vel = clamp(nv, ST_MIN, ST_MAX, sat);
          m_caa = clamp(p00 - signed_product(k0, p00, GAIN_FRAC), 0, COV_MAX, sat);
          m_cav = clamp(p01 - signed_product(k0, p01, GAIN_FRAC), COV_MIN, COV_MAX, sat);
          m_cva = clamp(m_cva - signed_product(k1, p00, GAIN_FRAC), COV_MIN, COV_MAX, sat);
          m_cvv = clamp(m_cvv - signed_product(k1, p01, GAIN_FRAC), 0, COV_MAX, sat);
        end
      end
      OP_RESTART: begin
        m_alt = m_start_alt;
        m_vel = m_start_vel;
        m_caa = COV_ONE;
        m_cav = 0;
        m_cva = 0;
        m_cvv = COV_ONE;
      end
      default: ;
    endcase
    e.altitude  = m_alt[31:0];
    e.velocity  = m_vel[31:0];
    e.variance  = m_caa[46:0];
    e.saturated = sat;
    return e;
  endfunction

  // expectations from accepted requests; typed rows replace the prediction
  always @(posedge clk) begin
    request_t r;
    estimate_t e;
    if (!rst && sample_if.valid && sample_if.ready) begin
      r.op        = op_t'(sample_if.op);
      r.accel     = sample_if.accel;
      r.step_time = sample_if.step_time;
      r.baro      = sample_if.baro_altitude;
      e = filter_step(r);
      if (typed_flags.size() != 0 && typed_flags.pop_front()) e = typed_queue.pop_front();
      pending_estimates.push_back(e);
    end
  end

  always @(posedge clk) begin
    estimate_t e;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_estimates.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, got alt %h", $time,
                 result_if.altitude);
      end else begin
        e = pending_estimates.pop_front();
        if (result_if.altitude !== e.altitude) begin
          errors++;
          $display("%0t altitude: expected %h, got %h", $time, e.altitude,
                   result_if.altitude);
        end
        if (result_if.velocity !== e.velocity) begin
          errors++;
          $display("%0t velocity: expected %h, got %h", $time, e.velocity,
                   result_if.velocity);
        end
        if (result_if.altitude_variance !== e.variance) begin
          errors++;
          $display("%0t altitude_variance: expected %h, got %h", $time, e.variance,
                   result_if.altitude_variance);
        end
        if (result_if.saturated !== e.saturated) begin
          errors++;
          $display("%0t saturated: expected %b, got %b", $time, e.saturated,
                   result_if.saturated);
        end
      end
    end
  end

  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)
        || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("altitude_velocity_kalman_filter_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, or a long hold-off on request
  initial begin
    result_if.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 1500;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        result_if.ready = 1'b0;
        hold_left--;
      end else begin
        result_if.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    paddr   = {idx, 2'b00};
    pwdata  = val;
    pwrite  = 1'b1;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    case (idx)
      REG_PROCESS_NOISE:  m_process_noise = val;
      REG_MEASURE_NOISE:  m_measure_noise = val;
      REG_START_ALTITUDE: m_start_alt = longint'(signed'(val));
      REG_START_VELOCITY: m_start_vel = longint'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic send_request(request_t r);
    while ($urandom_range(99) < gap_pct) begin
      sample_if.valid = 1'b0;
      @(negedge clk);
    end
    typed_flags.push_back(r.typed);
    if (r.typed) typed_queue.push_back(r.want);
    sample_if.op            = r.op;
    sample_if.accel         = r.accel;
    sample_if.step_time     = r.step_time;
    sample_if.baro_altitude = r.baro;
    sample_if.valid         = 1'b1;
    do @(posedge clk); while (!sample_if.ready);
    @(negedge clk);
  endtask

  task automatic drain;
    sample_if.valid = 1'b0;
    while (pending_estimates.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic request_t make_row(op_t op, logic [31:0] acc, logic [15:0] dt,
                                        logic [31:0] baro);
    request_t r;
    r.op        = op;
    r.accel     = acc;
    r.step_time = dt;
    r.baro      = baro;
    r.typed     = 1'b0;
    r.want      = '{32'sd0, 32'sd0, 47'd0, 1'b0};
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(99);
    r = make_row(OP_PREDICT, 0, 0, 0);
    if (pick < 45) r.op = OP_PREDICT;
    else if (pick < 85) r.op = OP_UPDATE;
    else if (pick < 93) r.op = OP_RESTART;
    else r.op = OP_NONE;
    r.accel = ($urandom_range(3) == 0) ? $urandom
              : 32'($urandom_range(40 * 65536)) - 32'(20 * 65536);
    r.step_time = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(6554));
    r.baro = ($urandom_range(4) == 0) ? $urandom
             : m_alt[31:0] + 32'($urandom_range(20 * 65536)) - 32'(10 * 65536);
    return r;
  endfunction

  task automatic random_phase(int count, int gap, int stall);
    gap_pct = gap;
    stall_pct = stall;
    repeat (count) send_request(random_request());
    drain();
  endtask

  initial begin
    request_t r;
    estimate_t home;
    errors = 0;
    gap_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_if.valid = 1'b0;
    sample_if.op = OP_NONE;
    sample_if.accel = '0;
    sample_if.step_time = '0;
    sample_if.baro_altitude = '0;
    m_process_noise = 6554;
    m_measure_noise = 131072;
    m_start_alt = 0;
    m_start_vel = 0;
    m_alt = 0;
    m_vel = 0;
    m_caa = COV_ONE;
    m_cav = 0;
    m_cva = 0;
    m_cvv = COV_ONE;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    home = '{32'sd0, 32'sd0, 47'(COV_ONE), 1'b0};
    r = make_row(OP_NONE, 32'h7FFFFFFF, 16'hFFFF, 32'h80000000);
    r.typed = 1'b1;
    r.want = home;
    directed_rows.push_back(r);
    r.op = OP_RESTART;
    directed_rows.push_back(r);
    r = make_row(OP_PREDICT, 0, 0, 0);
    r.typed = 1'b1;
    r.want = home;
    directed_rows.push_back(r);
    directed_rows.push_back(make_row(OP_PREDICT, 32'h7FFFFFFF, 16'hFFFF, 0));
    directed_rows.push_back(make_row(OP_PREDICT, 32'h7FFFFFFF, 16'hFFFF, 0));
    directed_rows.push_back(make_row(OP_PREDICT, 32'h7FFFFFFF, 16'hFFFF, 0));
    directed_rows.push_back(make_row(OP_UPDATE, 0, 0, 32'h80000000));
    directed_rows.push_back(make_row(OP_UPDATE, 0, 0, 32'h7FFFFFFF));
    directed_rows.push_back(make_row(OP_RESTART, 0, 0, 0));
    directed_rows.push_back(make_row(OP_PREDICT, 32'h80000000, 16'hFFFF, 0));
    directed_rows.push_back(make_row(OP_PREDICT, 32'h80000000, 16'hFFFF, 0));
    directed_rows.push_back(make_row(OP_PREDICT, 32'h80000000, 16'd1, 0));
    directed_rows.push_back(make_row(OP_UPDATE, 32'h7FFFFFFF, 16'hFFFF, 32'h00000000));
    directed_rows.push_back(make_row(OP_UPDATE, 0, 0, 32'hFFFFFFFF));
    directed_rows.push_back(make_row(OP_NONE, 0, 0, 0));
    directed_rows.push_back(make_row(OP_RESTART, 0, 0, 0));
    directed_rows.push_back(make_row(OP_PREDICT, 32'h00010000, 16'd6554, 0));
    directed_rows.push_back(make_row(OP_UPDATE, 0, 0, 32'h00050000));
    foreach (directed_rows[i]) send_request(directed_rows[i]);
    drain();

    // extremes of the registers
    write_reg(REG_PROCESS_NOISE, 32'hFFFFFFFF);
    write_reg(REG_MEASURE_NOISE, 32'hFFFFFFFF);
    write_reg(REG_START_ALTITUDE, 32'h80000000);
    write_reg(REG_START_VELOCITY, 32'h7FFFFFFF);
    send_request(make_row(OP_RESTART, 0, 0, 0));
    send_request(make_row(OP_PREDICT, 32'h7FFFFFFF, 16'hFFFF, 0));
    send_request(make_row(OP_UPDATE, 0, 0, 32'h7FFFFFFF));
    send_request(make_row(OP_PREDICT, 32'h80000000, 16'hFFFF, 0));
    drain();

    // zero measurement noise drives P00 to zero, then P00 + R is zero
    write_reg(REG_PROCESS_NOISE, 32'd0);
    write_reg(REG_MEASURE_NOISE, 32'd0);
    write_reg(REG_START_ALTITUDE, 32'h7FFFFFFF);
    write_reg(REG_START_VELOCITY, 32'h80000000);
    send_request(make_row(OP_RESTART, 0, 0, 0));
    send_request(make_row(OP_UPDATE, 0, 0, 32'h00000000));
    send_request(make_row(OP_UPDATE, 0, 0, 32'h12345678));
    send_request(make_row(OP_PREDICT, 0, 16'd0, 0));
    drain();

    write_reg(REG_PROCESS_NOISE, 32'd6554);
    write_reg(REG_MEASURE_NOISE, 32'd1);
    write_reg(REG_START_ALTITUDE, 32'd0);
    write_reg(REG_START_VELOCITY, 32'd0);
    random_phase(100, 0, 0);

    write_reg(REG_PROCESS_NOISE, $urandom_range(65536 * 4));
    write_reg(REG_MEASURE_NOISE, 1 + $urandom_range(65536 * 8));
    write_reg(REG_START_ALTITUDE, $urandom);
    write_reg(REG_START_VELOCITY, $urandom);
    random_phase(100, 57, 0);

    write_reg(REG_PROCESS_NOISE, $urandom);
    write_reg(REG_MEASURE_NOISE, $urandom);
    random_phase(100, 0, 57);

    write_reg(REG_PROCESS_NOISE, 32'd655);
    write_reg(REG_MEASURE_NOISE, 32'd131072);
    write_reg(REG_START_ALTITUDE, 32'h00640000);
    random_phase(100, 28, 28);

    // hold the result side off while requests keep coming
    gap_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    repeat (25) send_request(random_request());
    drain();

    if (errors == 0) begin
      $display("altitude_velocity_kalman_filter_test passed");
    end else begin
      $display("altitude_velocity_kalman_filter_test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/akf_pkg.sv
src/akf_ifs.sv
src/akf_mul.sv
src/akf_div.sv
src/akf_dp.sv
src/akf_ctrl.sv
src/altitude_velocity_kalman_filter.sv
tb/sv/altitude_velocity_kalman_filter_test.sv
